>>> src/lfsi_pkg.sv
// Package for the four-species lattice interaction core.
// Item types, code constants, defaults and the predation rule.
// Depends on nothing; used by the core and its checker.
`timescale 1ns / 1ps
`default_nettype none

package lfsi_pkg;

  // Default lattice size
  localparam int GRID_ROWS_DEF = 256;
  localparam int GRID_COLS_DEF = 256;

  // Species count and field widths
  localparam logic [2:0] SPECIES = 3'd4;
  localparam int PROB_W = 17;
  localparam int DRAW_W = 16;
  localparam int CFG_IDX_W = 2;

  // Request modes
  localparam logic [1:0] MODE_LOAD     = 2'd0;
  localparam logic [1:0] MODE_READ     = 2'd1;
  localparam logic [1:0] MODE_INTERACT = 2'd2;

  // Neighbour directions
  localparam logic [1:0] DIR_ROW_INC = 2'd0;
  localparam logic [1:0] DIR_ROW_DEC = 2'd1;
  localparam logic [1:0] DIR_COL_INC = 2'd2;
  localparam logic [1:0] DIR_COL_DEC = 2'd3;

  // Result events
  localparam logic [2:0] EV_REJECTED   = 3'd0;
  localparam logic [2:0] EV_MOVED      = 3'd1;
  localparam logic [2:0] EV_PREYED     = 3'd2;
  localparam logic [2:0] EV_REPRODUCED = 3'd3;
  localparam logic [2:0] EV_NO_CHANGE  = 3'd4;
  localparam logic [2:0] EV_ACCESS     = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOBILITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREDATION = 2'd1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FETCH,
    ST_EXEC
  } state_t;

  // Request item
  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        row;
    logic [7:0]        col;
    logic [1:0]        direction;
    logic [DRAW_W-1:0] action_draw;
    logic [2:0]        cell_value;
  } req_item_t;

  // Response item
  typedef struct packed {
    logic [2:0] event_res;
    logic       counted;
    logic [2:0] read_value;
    logic [2:0] neighbor_after;
  } rsp_item_t;

  // Active species a preys on the next and second-next species, cyclically
  function automatic logic preys_on(input logic [2:0] a, input logic [2:0] p);
    logic [1:0] a_inc;
    logic [2:0] first;
    logic [2:0] second;
    a_inc  = a[1:0] + 2'd1;
    first  = {1'b0, a[1:0]} + 3'd1;
    second = {1'b0, a_inc} + 3'd1;
    return (p == first) || (p == second);
  endfunction

endpackage

`default_nettype wire

>>> src/lattice_four_species_interaction_core.sv
// Four-species cyclic competition on a toroidal lattice.
// Usage, timing and reset behaviour are described below.
// Depends on lfsi_pkg.
//
// Request channel (req_valid/req_ready/req_item): load a cell, read a cell
// or run one interaction of an active cell with a wrapped neighbour.
// Response channel (rsp_valid/rsp_ready/rsp_item): one item per request.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes the
// mobility and predation probabilities; always ready. The user must write
// them only while idle; the block itself does not enforce it.
// Each request runs through these steps in order: accept (quotient estimate
// of row and column), remainder correction, grid read on both ports of the
// dual-port grid memory, then decision and write-back. The response is
// registered at write-back; the next request is taken only after it.
// The read-then-write on the grid memory is serialised by the sequencer, so
// accesses of successive items never overlap.
// If the receiver stalls, the next request is still accepted and carried up
// to the grid read, where it waits until the response register is free.
// Reset clears the sequencer, the response valid and both probabilities.
// Grid contents are undefined until loaded; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module lattice_four_species_interaction_core #(
  parameter int GRID_ROWS = lfsi_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = lfsi_pkg::GRID_COLS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_ready,
  input  wire lfsi_pkg::req_item_t            req_item,
  output logic                                rsp_valid,
  input  wire logic                           rsp_ready,
  output lfsi_pkg::rsp_item_t                 rsp_item,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lfsi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lfsi_pkg::PROB_W-1:0]    cfg_data
);

  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int DEPTH  = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int REM_W  = 24;
  // Reciprocals for the modulo reduction of 8-bit coordinates
  localparam int ROW_RECIP = 65536 / GRID_ROWS;
  localparam int COL_RECIP = 65536 / GRID_COLS;

  // Sequencer and control
  lfsi_pkg::state_t state, state_next;
  logic capture;
  logic out_free;
  logic load_rsp;

  // Configuration registers
  logic [lfsi_pkg::PROB_W-1:0] mobility_prob;
  logic [lfsi_pkg::PROB_W-1:0] predation_prob;

  // Captured request
  logic [1:0]                  mode_q;
  logic [7:0]                  row_raw, col_raw;
  logic [7:0]                  row_quo, col_quo;
  logic [1:0]                  dir_q;
  logic [lfsi_pkg::DRAW_W-1:0] draw_q;
  logic [2:0]                  val_q;
  logic [24:0]                 row_prod, col_prod;

  // Reduced coordinates
  logic [ROW_W-1:0] row_r, row_r_next, nrow;
  logic [COL_W-1:0] col_r, col_r_next, ncol;
  logic [REM_W-1:0] row_rem, col_rem;

  // Grid memory and its ports
  logic [2:0]        grid_cells [DEPTH];
  logic [ADDR_W-1:0] act_addr, act_addr_next, pas_addr, pas_addr_next;
  logic [ADDR_W-1:0] addr_a, addr_b;
  logic              we_a, we_b;
  logic [2:0]        rd_a, rd_b;

  // Decision outputs
  logic                we_a_req, we_b_req;
  logic [2:0]          wd_a, wd_b;
  lfsi_pkg::rsp_item_t rsp_next;
  logic [lfsi_pkg::PROB_W:0] prob_sum;
  logic [2:0]                load_val;

  assign out_free  = !rsp_valid || rsp_ready;
  assign cfg_ready = 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lfsi_pkg::ST_IDLE:   if (req_valid) state_next = lfsi_pkg::ST_REDUCE;
      lfsi_pkg::ST_REDUCE: state_next = lfsi_pkg::ST_FETCH;
      lfsi_pkg::ST_FETCH:  if (out_free) state_next = lfsi_pkg::ST_EXEC;
      lfsi_pkg::ST_EXEC:   state_next = lfsi_pkg::ST_IDLE;
      default:             state_next = lfsi_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, port addressing and write strobes
  always_comb begin
    req_ready = 1'b0;
    load_rsp  = 1'b0;
    we_a      = 1'b0;
    we_b      = 1'b0;
    addr_a    = act_addr_next;
    addr_b    = pas_addr_next;
    case (state)
      lfsi_pkg::ST_IDLE: req_ready = 1'b1;
      lfsi_pkg::ST_EXEC: begin
        load_rsp = 1'b1;
        we_a     = we_a_req;
        we_b     = we_b_req;
        addr_a   = act_addr;
        addr_b   = pas_addr;
      end
      default: ;
    endcase
  end

  assign capture = req_valid && req_ready;

  // Quotient estimate: floor(v * floor(2^16/N) / 2^16) is q or q-1
  assign row_prod = 25'(req_item.row) * 25'(ROW_RECIP);
  assign col_prod = 25'(req_item.col) * 25'(COL_RECIP);

  // Remainder with one correction step
  always_comb begin
    row_rem = REM_W'(row_raw) - REM_W'(row_quo) * REM_W'(GRID_ROWS);
    col_rem = REM_W'(col_raw) - REM_W'(col_quo) * REM_W'(GRID_COLS);
    if (row_rem >= REM_W'(GRID_ROWS)) row_r_next = ROW_W'(row_rem - REM_W'(GRID_ROWS));
    else row_r_next = ROW_W'(row_rem);
    if (col_rem >= REM_W'(GRID_COLS)) col_r_next = COL_W'(col_rem - REM_W'(GRID_COLS));
    else col_r_next = COL_W'(col_rem);
  end

  // Wrapped neighbour and linear addresses
  always_comb begin
    nrow = row_r;
    ncol = col_r;
    case (dir_q)
      lfsi_pkg::DIR_ROW_INC:
        nrow = (row_r == ROW_W'(GRID_ROWS - 1)) ? '0 : row_r + 1'b1;
      lfsi_pkg::DIR_ROW_DEC:
        nrow = (row_r == '0) ? ROW_W'(GRID_ROWS - 1) : row_r - 1'b1;
      lfsi_pkg::DIR_COL_INC:
        ncol = (col_r == COL_W'(GRID_COLS - 1)) ? '0 : col_r + 1'b1;
      lfsi_pkg::DIR_COL_DEC:
        ncol = (col_r == '0) ? COL_W'(GRID_COLS - 1) : col_r - 1'b1;
      default: ;
    endcase
    act_addr_next = ADDR_W'(int'(row_r) * GRID_COLS + int'(col_r));
    pas_addr_next = ADDR_W'(int'(nrow) * GRID_COLS + int'(ncol));
  end

  // Decision on the fetched active and neighbour cells
  always_comb begin
    we_a_req = 1'b0;
    we_b_req = 1'b0;
    wd_a     = rd_b;
    wd_b     = rd_a;
    rsp_next = '0;
    rsp_next.event_res = lfsi_pkg::EV_NO_CHANGE;
    prob_sum = {1'b0, mobility_prob} + {1'b0, predation_prob};
    load_val = (val_q > lfsi_pkg::SPECIES) ? lfsi_pkg::SPECIES : val_q;
    case (mode_q)
      lfsi_pkg::MODE_LOAD: begin
        we_a_req = 1'b1;
        wd_a     = load_val;
        rsp_next.event_res  = lfsi_pkg::EV_ACCESS;
        rsp_next.read_value = load_val;
      end
      lfsi_pkg::MODE_READ: begin
        rsp_next.event_res  = lfsi_pkg::EV_ACCESS;
        rsp_next.read_value = rd_a;
      end
      lfsi_pkg::MODE_INTERACT: begin
        rsp_next.read_value     = rd_a;
        rsp_next.neighbor_after = rd_b;
        if (rd_a == 3'd0) begin
          rsp_next.event_res = lfsi_pkg::EV_REJECTED;
        end else if ({1'b0, draw_q} < mobility_prob) begin
          // mobility: swap the two cells
          we_a_req = 1'b1;
          we_b_req = 1'b1;
          wd_a     = rd_b;
          wd_b     = rd_a;
          rsp_next.event_res      = lfsi_pkg::EV_MOVED;
          rsp_next.counted        = 1'b1;
          rsp_next.read_value     = rd_b;
          rsp_next.neighbor_after = rd_a;
        end else if ({2'b0, draw_q} <= prob_sum) begin
          // predation on the next or second-next species
          if (lfsi_pkg::preys_on(rd_a, rd_b)) begin
            we_b_req = 1'b1;
            wd_b     = 3'd0;
            rsp_next.event_res      = lfsi_pkg::EV_PREYED;
            rsp_next.counted        = 1'b1;
            rsp_next.neighbor_after = 3'd0;
          end
        end else if (rd_b == 3'd0) begin
          // reproduction into an empty neighbour
          we_b_req = 1'b1;
          wd_b     = rd_a;
          rsp_next.event_res      = lfsi_pkg::EV_REPRODUCED;
          rsp_next.counted        = 1'b1;
          rsp_next.neighbor_after = rd_a;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= lfsi_pkg::ST_IDLE;
      rsp_valid      <= 1'b0;
      mobility_prob  <= '0;
      predation_prob <= '0;
    end else begin
      state <= state_next;
      if (load_rsp) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lfsi_pkg::CFG_MOBILITY:  mobility_prob  <= cfg_data;
          lfsi_pkg::CFG_PREDATION: predation_prob <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (capture) begin
      mode_q  <= req_item.mode;
      row_raw <= req_item.row;
      col_raw <= req_item.col;
      row_quo <= row_prod[23:16];
      col_quo <= col_prod[23:16];
      dir_q   <= req_item.direction;
      draw_q  <= req_item.action_draw;
      val_q   <= req_item.cell_value;
    end
    if (state == lfsi_pkg::ST_REDUCE) begin
      row_r <= row_r_next;
      col_r <= col_r_next;
    end
    if (state == lfsi_pkg::ST_FETCH) begin
      act_addr <= act_addr_next;
      pas_addr <= pas_addr_next;
    end
    if (load_rsp) rsp_item <= rsp_next;
  end

  // Dual-port grid memory, registered reads
  always_ff @(posedge clk) begin
    if (we_a) grid_cells[addr_a] <= wd_a;
    if (we_b) grid_cells[addr_b] <= wd_b;
    rd_a <= grid_cells[addr_a];
    rd_b <= grid_cells[addr_b];
  end

endmodule

`default_nettype wire

>>> src/lfsi_checker.sv
// Port-level checks for the four-species lattice interaction core.
// Bound to lattice_four_species_interaction_core; depends on lfsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfsi_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_ready,
  input wire lfsi_pkg::req_item_t req_item,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire lfsi_pkg::rsp_item_t rsp_item
);

  logic req_acc;
  assign req_acc = req_valid && req_ready;

  // A stalled response item holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
    else $error("response item changed while stalled");

  // One item in flight: no request taken right after another
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> !req_ready)
    else $error("request taken while one is in flight");

  // The response valid does not rise while the request is in reduction or fetch
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    req_acc |-> ##1 !$rose(rsp_valid) ##1 !$rose(rsp_valid))
    else $error("response earlier than the pipeline allows");

  // Only a real move, predation or reproduction counts
  a_counted_event: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.counted |->
      (rsp_item.event_res == lfsi_pkg::EV_MOVED) ||
      (rsp_item.event_res == lfsi_pkg::EV_PREYED) ||
      (rsp_item.event_res == lfsi_pkg::EV_REPRODUCED))
    else $error("counted set on an event that does not count");

  // req_item is not checked; it is only reduced here to mark it as used
  logic unused_req;
  assign unused_req = ^req_item;

endmodule

bind lattice_four_species_interaction_core lfsi_checker u_lfsi_checker (.*);

`default_nettype wire
